/* hdl/ckore_pkg.sv */
// ----------------------------------------------------------------------------
// ckore_pkg
// shared types and constants of the chroma key opaque run extractor
// ----------------------------------------------------------------------------
package ckore_pkg;

   localparam int COORD_W    = 12;
   localparam int WIDTH_W    = 13;
   localparam int STEP_W     = 5;
   localparam int BYTE_W     = 8;
   localparam int MAX_SIDE   = 4096;
   localparam int SAT_W      = 17;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   // register index, byte address = 4 * index
   typedef enum logic [2:0] {
      REG_GREEN_MIN   = 3'd0,
      REG_RED_MAX     = 3'd1,
      REG_BLUE_MAX    = 3'd2,
      REG_IMAGE_WIDTH = 3'd3,
      REG_ROW_STEP    = 3'd4
   } reg_index_type;

   localparam logic [BYTE_W-1:0]  GREEN_MIN_RESET   = 8'd153;
   localparam logic [BYTE_W-1:0]  RED_MAX_RESET     = 8'd89;
   localparam logic [BYTE_W-1:0]  BLUE_MAX_RESET    = 8'd89;
   localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET = 13'd4096;
   localparam logic [STEP_W-1:0]  ROW_STEP_RESET    = 5'd2;

   typedef struct packed {
      logic [BYTE_W-1:0]  green_min;
      logic [BYTE_W-1:0]  red_max;
      logic [BYTE_W-1:0]  blue_max;
      logic [WIDTH_W-1:0] image_width;
      logic [STEP_W-1:0]  row_step;
   } cfg_type;

   // one closed run handed from front to back
   typedef struct packed {
      logic [COORD_W-1:0] start;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] end_x;
      logic               flush;
   } cmd_type;

endpackage

/* hdl/ckore_front.sv */
// ----------------------------------------------------------------------------
// ckore_front
// classifies each pixel as key or opaque and tracks the open run
// ----------------------------------------------------------------------------
module ckore_front (
   input  logic                     clock,
   input  logic                     reset,
   input  ckore_pkg::cfg_type       cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [11:0]              req_pixel_x,
   input  logic [11:0]              req_pixel_y,
   input  logic [7:0]               req_red,
   input  logic [7:0]               req_green,
   input  logic [7:0]               req_blue,
   input  logic                     req_row_end,
   input  logic                     q_full,
   output logic                     q_push,
   output ckore_pkg::cmd_type       q_cmd
);
   import ckore_pkg::*;

   logic               run_open_ff, run_open_in;
   logic [COORD_W-1:0] run_start_ff, run_start_in;
   logic               is_key;
   logic               accept;
   logic               emit;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_key    = (req_green >= cfg.green_min) && (req_red <= cfg.red_max)
                      && (req_blue <= cfg.blue_max);

   always_comb begin
      run_open_in  = run_open_ff;
      run_start_in = run_start_ff;
      emit         = 1'b0;
      q_cmd.row    = req_pixel_y;
      q_cmd.end_x  = req_pixel_x;
      q_cmd.flush  = !is_key;
      q_cmd.start  = run_open_ff ? run_start_ff : req_pixel_x;
      if (accept) begin
         if (is_key) begin
            emit        = run_open_ff;
            run_open_in = 1'b0;
         end else begin
            // opaque pixel opens a run if none is open
            if (!run_open_ff) begin
               run_start_in = req_pixel_x;
            end
            run_open_in = 1'b1;
            emit        = req_row_end;
         end
         if (req_row_end) begin
            run_open_in = 1'b0;
         end
      end
   end

   assign q_push = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff  <= 1'b0;
         run_start_ff <= '0;
      end else begin
         run_open_ff  <= run_open_in;
         run_start_ff <= run_start_in;
      end
   end

endmodule

/* hdl/ckore_queue.sv */
// ----------------------------------------------------------------------------
// ckore_queue
// short first-in first-out queue of closed runs
// ----------------------------------------------------------------------------
module ckore_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ckore_pkg::cmd_type push_cmd,
   input  logic               pop,
   output ckore_pkg::cmd_type pop_cmd,
   output logic               empty,
   output logic               full
);
   import ckore_pkg::*;

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hdl/ckore_back.sv */
// ----------------------------------------------------------------------------
// ckore_back
// turns a closed run into a rectangle and holds it in the output register
// ----------------------------------------------------------------------------
module ckore_back (
   input  logic               clock,
   input  logic               reset,
   input  ckore_pkg::cfg_type cfg,
   input  logic               q_empty,
   input  ckore_pkg::cmd_type q_cmd,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [11:0]        rsp_rect_x,
   output logic [11:0]        rsp_rect_y,
   output logic [12:0]        rsp_rect_width,
   output logic [4:0]         rsp_rect_height
);
   import ckore_pkg::*;

   logic               valid_ff, valid_in;
   logic [COORD_W-1:0] rect_x_ff;
   logic [COORD_W-1:0] rect_y_ff;
   logic [WIDTH_W-1:0] rect_width_ff, rect_width_in;
   logic [STEP_W-1:0]  rect_height_ff;
   logic [SAT_W-1:0]   width_sat;
   logic [WIDTH_W-1:0] end_pos;

   assign q_pop = !q_empty && (!valid_ff || rsp_ready);

   always_comb begin
      // image width clipped to the largest side
      width_sat = ({{(SAT_W-WIDTH_W){1'b0}}, cfg.image_width} > SAT_W'(MAX_SIDE))
                  ? SAT_W'(MAX_SIDE)
                  : {{(SAT_W-WIDTH_W){1'b0}}, cfg.image_width};
      end_pos   = q_cmd.flush ? width_sat[WIDTH_W-1:0] : {1'b0, q_cmd.end_x};
      rect_width_in = end_pos - {1'b0, q_cmd.start};
      valid_in  = q_pop ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rect_x_ff      <= q_cmd.start;
         rect_y_ff      <= q_cmd.row;
         rect_width_ff  <= rect_width_in;
         rect_height_ff <= cfg.row_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_rect_x      = rect_x_ff;
   assign rsp_rect_y      = rect_y_ff;
   assign rsp_rect_width  = rect_width_ff;
   assign rsp_rect_height = rect_height_ff;

endmodule

/* hdl/chroma_key_opaque_run_extractor.sv */
// ----------------------------------------------------------------------------
// chroma_key_opaque_run_extractor
// finds runs of non-key pixels in a sampled raster and reports rectangles
// ----------------------------------------------------------------------------
// usage:
//  - req channel: one sampled pixel per word (column, row, rgb, row end mark),
//    valid/ready; a word is taken every clock while the run queue has room
//  - rsp channel: one rectangle word (x, y, width, height) per closed run
//  - csr port: apb-style, registers at byte offsets 0,4,8,12,16 for green_min,
//    red_max, blue_max, image_width, row_step; pready is tied high
//  - a closed run is written to a queue slot, then to the output register, and
//    shows on rsp from there; one pixel per clock while the queue has room
//  - the front keeps the run state and writes closed runs into a four-entry
//    queue; the back computes widths into the output register
//  - when the receiver stalls the output register holds, the queue fills and
//    req_ready drops only once all four entries are taken
//  - reset clears the run state, the queue and the output valid, and loads
//    the register defaults
// ----------------------------------------------------------------------------
module chroma_key_opaque_run_extractor (
   input  logic        clock,
   input  logic        reset,
   // pixel input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_pixel_x,
   input  logic [11:0] req_pixel_y,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_row_end,
   // rectangle output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_rect_x,
   output logic [11:0] rsp_rect_y,
   output logic [12:0] rsp_rect_width,
   output logic [4:0]  rsp_rect_height,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ckore_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type csr_index;
   logic          csr_write;
   logic          q_push, q_pop, q_empty, q_full;
   cmd_type       push_cmd, pop_cmd;

   // register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_GREEN_MIN:   cfg_in.green_min   = csr_pwdata[BYTE_W-1:0];
            REG_RED_MAX:     cfg_in.red_max     = csr_pwdata[BYTE_W-1:0];
            REG_BLUE_MAX:    cfg_in.blue_max    = csr_pwdata[BYTE_W-1:0];
            REG_IMAGE_WIDTH: cfg_in.image_width = csr_pwdata[WIDTH_W-1:0];
            REG_ROW_STEP:    cfg_in.row_step    = csr_pwdata[STEP_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_GREEN_MIN:   csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, cfg_ff.green_min};
         REG_RED_MAX:     csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, cfg_ff.red_max};
         REG_BLUE_MAX:    csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, cfg_ff.blue_max};
         REG_IMAGE_WIDTH: csr_prdata = {{(CSR_DATA_W-WIDTH_W){1'b0}}, cfg_ff.image_width};
         REG_ROW_STEP:    csr_prdata = {{(CSR_DATA_W-STEP_W){1'b0}}, cfg_ff.row_step};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.green_min   <= GREEN_MIN_RESET;
         cfg_ff.red_max     <= RED_MAX_RESET;
         cfg_ff.blue_max    <= BLUE_MAX_RESET;
         cfg_ff.image_width <= IMAGE_WIDTH_RESET;
         cfg_ff.row_step    <= ROW_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: classify and track the open run
   ckore_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_pixel_x (req_pixel_x),
      .req_pixel_y (req_pixel_y),
      .req_red     (req_red),
      .req_green   (req_green),
      .req_blue    (req_blue),
      .req_row_end (req_row_end),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   // closed runs waiting for the back end
   ckore_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   // back: width arithmetic and output register
   ckore_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_empty         (q_empty),
      .q_cmd           (pop_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rect_x      (rsp_rect_x),
      .rsp_rect_y      (rsp_rect_y),
      .rsp_rect_width  (rsp_rect_width),
      .rsp_rect_height (rsp_rect_height)
   );

endmodule
